>>> hw/rtl/multi_waveform_shaper_top_assert.svh
// Assertion macros for the waveform shaper.
// Needs a clk and rst in the scope where they are used.
`ifndef MULTI_WAVEFORM_SHAPER_TOP_ASSERT_SVH
`define MULTI_WAVEFORM_SHAPER_TOP_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define MWS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("shaper implication check failed");

// Plain condition checked at every clock edge outside reset.
`define MWS_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("shaper invariant check failed");

`endif

>>> hw/rtl/mws_pkg.sv
// Shared codes and constants for the waveform shaper.
// No dependencies.
`default_nettype none
package mws_pkg;

  typedef enum logic [3:0] {
    WF_SINE      = 4'd0,
    WF_COSINE    = 4'd1,
    WF_TRIANGLE  = 4'd2,
    WF_SIGNSIN   = 4'd3,
    WF_RECTANGLE = 4'd4,
    WF_SAWRISE   = 4'd5,
    WF_SAWFALL   = 4'd6,
    WF_TRAPEZE   = 4'd7,
    WF_PWM       = 4'd8
  } wave_t;

  typedef enum logic [1:0] {
    REG_WAVEFORM    = 2'd0,
    REG_AMPLITUDE   = 2'd1,
    REG_PULSE_WIDTH = 2'd2
  } reg_idx_t;

  localparam logic [3:0]  WAVEFORM_RST    = 4'd0;
  localparam logic [14:0] AMPLITUDE_RST   = 15'd32767;
  localparam logic [14:0] PULSE_WIDTH_RST = 15'd24576;

  localparam logic signed [31:0] Q30_ONE  = 32'sd1073741824;
  localparam logic signed [31:0] Q30_HALF = 32'sd536870912;
  localparam logic [63:0] HALF_PI_Q30     = 64'd1686629713;
  localparam logic [14:0] PW_ONE          = 15'd16384;
  localparam int QUO_BITS                 = 31;

endpackage
`default_nettype wire

>>> hw/rtl/multi_waveform_shaper_top.sv
// Waveform shaper top level: config registers, sine ROM, shape logic,
// pipelined trapeze divider, scaling and saturation.
// Depends on mws_pkg and multi_waveform_shaper_top_assert.svh.
//
//  channel   dir  handshake                 payload
//  s_*       in   s_tvalid / s_tready       s_tdata: phase
//  m_*       out  m_tvalid / m_tready       m_tdata: sample
//  apb       in   psel, penable, pwrite     paddr, pwdata -> prdata, pready=1
//
// One item per clock while the output is not stalled; the trapeze slopes are formed
// by the 31-step restoring divider.
// Whole pipeline advances together when the output register is empty or taken;
// a stall freezes every stage, so nothing is lost or repeated.
// Reset (synchronous, high) clears the valid bits and loads register defaults.
`default_nettype none
`include "multi_waveform_shaper_top_assert.svh"

module multi_waveform_shaper_top
  import mws_pkg::*;
#(
  parameter int PHASE_BITS       = 24,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [((PHASE_BITS+7)/8)*8-1:0]  s_tdata,   // [PHASE_BITS-1:0] phase
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [15:0]                           m_tdata,   // [15:0] sample
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [3:0]                       paddr,
  input  wire logic [31:0]                      pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  localparam int AW     = $clog2(SINE_TABLE_DEPTH);
  localparam int IDX_SH = 30 - AW;
  localparam int PH_SH  = 32 - PHASE_BITS;

  typedef logic [16:0] rom_t [0:SINE_TABLE_DEPTH];

  // Quarter-wave sine, Q1.15, built at elaboration by integer Taylor series.
  function automatic rom_t build_rom();
    rom_t                r;
    logic [63:0]         x;
    logic [63:0]         x2;
    logic [63:0]         term;
    logic signed [63:0]  sum;
    logic signed [63:0]  v;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x    = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int n = 1; n <= 12; n++) begin
        term = (term * x2) >> 30;
        term = term / 64'((2 * n) * (2 * n + 1));
        if ((n % 2) == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = 64'sd0;
      end
      v = (sum + 64'sd16384) >>> 15;
      if (v > 64'sd32768) begin
        v = 64'sd32768;
      end
      r[k] = v[16:0];
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // ---------------- configuration registers ----------------
  logic [3:0]  waveform;
  logic [14:0] amplitude;
  logic [14:0] pulse_width;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      waveform    <= WAVEFORM_RST;
      amplitude   <= AMPLITUDE_RST;
      pulse_width <= PULSE_WIDTH_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_WAVEFORM:    waveform    <= pwdata[3:0];
        REG_AMPLITUDE:   amplitude   <= pwdata[14:0];
        REG_PULSE_WIDTH: pulse_width <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_WAVEFORM:    prdata = {28'd0, waveform};
      REG_AMPLITUDE:   prdata = {17'd0, amplitude};
      REG_PULSE_WIDTH: prdata = {17'd0, pulse_width};
      default:         prdata = 32'd0;
    endcase
  end

  // Register-driven; user keeps them stable while items are in flight, not enforced.
  logic [14:0] pw_clamp;
  logic [31:0] tz_len;
  logic [31:0] tz_p1;     // also the divisor for both slopes
  logic [32:0] tz_p3;

  assign pw_clamp = (pulse_width < PW_ONE) ? PW_ONE : pulse_width;
  assign tz_len   = {2'b00, pw_clamp[13:0], 16'd0} & {32{pulse_width >= PW_ONE}};
  assign tz_p1    = 32'h8000_0000 - tz_len;
  assign tz_p3    = 33'h1_0000_0000 - {1'b0, tz_len};

  // ---------------- pipeline control ----------------
  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // Stage 1: phase as a 32-bit fraction.
  logic        v1;
  logic [31:0] u1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u1 <= 32'(s_tdata[PHASE_BITS-1:0]) << PH_SH;
    end
  end

  // Stage 1 comb: ROM address, pwm product bit.
  logic [31:0] look_u;
  logic [AW-1:0] look_idx;
  logic [AW:0] rom_addr;
  logic [46:0] pwm_prod;

  assign look_u   = (wave_t'(waveform) == WF_COSINE) ? u1 + 32'h4000_0000 : u1;
  assign look_idx = AW'(look_u[29:0] >> IDX_SH);
  assign rom_addr = look_u[30] ? (AW+1)'(SINE_TABLE_DEPTH) - {1'b0, look_idx}
                               : {1'b0, look_idx};
  assign pwm_prod = 47'(u1) * 47'(pulse_width);

  // Stage 2: ROM data registered.
  logic        v2;
  logic [31:0] u2;
  logic [16:0] rom2;
  logic        neg2;
  logic        pwm2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u2   <= u1;
      rom2 <= SINE_ROM[rom_addr];
      neg2 <= look_u[31];
      pwm2 <= u1[31] & pwm_prod[45];
    end
  end

  // Stage 2 comb: shape value in Q.30, or a trapeze slope for the divider.
  logic signed [17:0] sin_t;
  logic signed [31:0] shape;
  logic               use_div;
  logic [31:0]        div_num;
  logic [32:0]        tri_d;

  always_comb begin
    sin_t   = neg2 ? -$signed({1'b0, rom2}) : $signed({1'b0, rom2});
    tri_d   = u2[31] ? {1'b0, u2} - 33'h0_8000_0000 : 33'h0_8000_0000 - {1'b0, u2};
    shape   = 32'sd0;
    use_div = 1'b0;
    div_num = u2;
    case (wave_t'(waveform))
      WF_SINE, WF_COSINE: shape = 32'(sin_t) <<< 15;
      WF_TRIANGLE:        shape = $signed(tri_d[31:0]) - Q30_ONE;
      WF_SIGNSIN: begin
        if ((19'(sin_t) + 19'sd32768) > $signed({3'b000, pulse_width, 1'b0})) begin
          shape = 32'(sin_t) <<< 15;
        end
      end
      WF_RECTANGLE: shape = u2[31] ? Q30_HALF : -Q30_HALF;
      WF_SAWRISE:   shape = $signed({2'b00, u2[31:2]});
      WF_SAWFALL:   shape = Q30_ONE - $signed({2'b00, u2[31:2]});
      WF_TRAPEZE: begin
        if (u2 < tz_p1) begin
          use_div = 1'b1;
          div_num = u2;
        end else if (!u2[31]) begin
          shape = Q30_ONE;
        end else if ({1'b0, u2} < tz_p3) begin
          use_div = 1'b1;
          div_num = 32'(tz_p3 - {1'b0, u2});
        end
      end
      WF_PWM:  shape = pwm2 ? Q30_ONE : 32'sd0;
      default: shape = 32'sd0;
    endcase
  end

  // ---------------- divider: (num << 30) / tz_p1, one quotient bit a stage --------
  logic                    dv_v   [0:QUO_BITS];
  logic                    dv_div [0:QUO_BITS];
  logic signed [31:0]      dv_s   [0:QUO_BITS];
  logic [31:0]             dv_rem [0:QUO_BITS];
  logic [QUO_BITS-1:0]     dv_quo [0:QUO_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (adv) begin
      dv_v[0] <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_div[0] <= use_div;
      dv_s[0]   <= shape;
      dv_rem[0] <= div_num;
      dv_quo[0] <= '0;
    end
  end

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
    logic [32:0] trial;
    logic        ge;

    assign trial = (k == 0) ? {1'b0, dv_rem[k]} : {dv_rem[k], 1'b0};
    assign ge    = trial >= {1'b0, tz_p1};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k+1] <= 1'b0;
      end else if (adv) begin
        dv_v[k+1] <= dv_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_div[k+1] <= dv_div[k];
        dv_s[k+1]   <= dv_s[k];
        dv_rem[k+1] <= ge ? 32'(trial - {1'b0, tz_p1}) : trial[31:0];
        dv_quo[k+1] <= {dv_quo[k][QUO_BITS-2:0], ge};
      end
    end
  end

  // ---------------- scale ----------------
  logic signed [31:0] s_final;
  logic               vm;
  logic signed [47:0] prod;

  assign s_final = dv_div[QUO_BITS] ? $signed({1'b0, dv_quo[QUO_BITS]}) : dv_s[QUO_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (adv) begin
      vm <= dv_v[QUO_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= 48'($signed({1'b0, amplitude})) * 48'(s_final);
    end
  end

  // ---------------- round half up, saturate, output register ----------------
  logic signed [47:0] rsum;
  logic signed [17:0] rhi;
  logic [15:0]        sat;

  assign rsum = prod + 48'sd536870912;
  assign rhi  = rsum[47:30];

  always_comb begin
    if (rhi > 18'sd32767) begin
      sat = 16'h7FFF;
    end else if (rhi < -18'sd32768) begin
      sat = 16'h8000;
    end else begin
      sat = rhi[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= vm;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= sat;
    end
  end

  // ---------------- checks ----------------
  `MWS_ASSERT_ALWAYS(a_ready_follows_out, s_tready == (!m_tvalid || m_tready))
  `MWS_ASSERT_IMP(a_div_rem_below, dv_v[QUO_BITS] && dv_div[QUO_BITS], dv_rem[QUO_BITS] < tz_p1)
  `MWS_ASSERT_IMP(a_quo_bounded, dv_v[QUO_BITS] && dv_div[QUO_BITS], dv_quo[QUO_BITS] <= 31'h4000_0000)
  `MWS_ASSERT_IMP(a_stall_holds, m_tvalid && !m_tready, ##1 m_tvalid && $stable(m_tdata))

endmodule
`default_nettype wire
